/* design/acia_pkg.sv */
package acia_pkg;

    // Command codes of an input beat
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Register select
    localparam logic [1:0] ADDR_DATA    = 2'd0;
    localparam logic [1:0] ADDR_STATUS  = 2'd1;
    localparam logic [1:0] ADDR_COMMAND = 2'd2;
    localparam logic [1:0] ADDR_CONTROL = 2'd3;

    // Status bits
    localparam logic [7:0] ST_IRQ     = 8'h80;
    localparam logic [7:0] ST_TXEMPTY = 8'h10;
    localparam logic [7:0] ST_RXFULL  = 8'h08;
    localparam logic [7:0] ST_OVERRUN = 8'h04;
    localparam logic [7:0] ST_LOWBITS = 8'h0F;

    // Command register bits
    localparam logic [7:0] CR_TXMASK = 8'h0C;
    localparam logic [7:0] CR_TXIRQ  = 8'h04;
    localparam logic [7:0] CR_ECHO   = 8'h10;
    localparam logic [7:0] CR_RESET  = 8'h1F;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] reg_addr;
        logic [7:0] write_data;
        logic       rx_ready;
        logic       tx_ready;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_data;
        logic       irq;
    } out_item_t;

endpackage

/* design/acia_stream_if.sv */
interface acia_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/acia_serial_register_model.sv */
// Serial adapter register model.
// Request beats pass the input register, then the result register.
// Throughput: one beat per cycle; a stalled response holds the output register
// and the input register keeps accepting until both stages are full.
// Reset (rst_n low, asynchronous): pipeline valids and state registers clear.
module acia_serial_register_model (
    input logic          clk,
    input logic          rst_n,
    acia_stream_if.sink   request,
    acia_stream_if.source response
);
    import acia_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t step_result;
    logic      advance;

    // Pipeline control
    assign advance       = in_valid_reg && (!out_valid_reg || response.ready);
    assign request.ready = !in_valid_reg || advance;

    acia_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .item   (in_data_reg),
        .result (step_result)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (request.ready)
            in_valid_reg <= request.valid;
    end

    always_ff @(posedge clk)
    begin
        if (request.ready && request.valid)
            in_data_reg <= request.data;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || response.ready)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= step_result;
    end

    assign response.valid = out_valid_reg;
    assign response.data  = out_data_reg;

endmodule

/* design/acia_regfile.sv */
module acia_regfile (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  acia_pkg::in_item_t item,
    output acia_pkg::out_item_t result
);
    import acia_pkg::*;

    logic [7:0] rx_data_reg, rx_data_next;
    logic [7:0] status_reg, status_next;
    logic [7:0] command_reg, command_next;
    logic [7:0] control_reg, control_next;
    logic       irq_reg, irq_next;

    // Next state and result of one beat
    always_comb
    begin
        logic recompute;
        logic active;
        recompute    = 1'b0;
        active       = 1'b0;
        rx_data_next = rx_data_reg;
        status_next  = status_reg;
        command_next = command_reg;
        control_next = control_reg;
        irq_next     = irq_reg;
        result       = '0;

        case (item.command)
            CMD_TICK:
            begin
                if (item.rx_ready)
                begin
                    if ((status_reg & ST_RXFULL) != 8'h00)
                        status_next = status_next | ST_OVERRUN;
                    rx_data_next = item.rx_byte;
                    status_next  = status_next | ST_RXFULL;
                    if ((command_reg & CR_ECHO) != 8'h00)
                    begin
                        result.tx_valid = 1'b1;
                        result.tx_data  = item.rx_byte;
                    end
                end
                if (item.tx_ready)
                    status_next = status_next | ST_TXEMPTY;
                recompute = item.rx_ready | item.tx_ready;
            end
            CMD_READ:
            begin
                case (item.reg_addr)
                    ADDR_DATA:
                    begin
                        status_next      = status_reg & ~ST_LOWBITS;
                        recompute        = 1'b1;
                        result.read_data = rx_data_reg;
                    end
                    ADDR_STATUS:  result.read_data = status_reg;
                    ADDR_COMMAND: result.read_data = command_reg;
                    default:      result.read_data = control_reg;
                endcase
            end
            CMD_WRITE:
            begin
                case (item.reg_addr)
                    ADDR_DATA:
                    begin
                        result.tx_valid = 1'b1;
                        result.tx_data  = item.write_data;
                    end
                    ADDR_STATUS:
                    begin
                        // soft reset
                        command_next = command_reg | CR_RESET;
                        status_next  = status_reg | ST_OVERRUN;
                    end
                    ADDR_COMMAND: command_next = item.write_data;
                    default:      control_next = item.write_data;
                endcase
                recompute = 1'b1;
            end
            default:
            begin
                // unused code: no change
            end
        endcase

        // Interrupt recompute on the updated registers
        if (recompute)
        begin
            active = ((status_next & ST_RXFULL) != 8'h00) ||
                     (((status_next & ST_TXEMPTY) != 8'h00) &&
                      ((command_next & CR_TXMASK) == CR_TXIRQ));
            if (active)
                status_next = status_next | ST_IRQ;
            else
                status_next = status_next & ~ST_IRQ;
            irq_next = active && ((command_next & CR_ECHO) != 8'h00);
        end

        result.irq = irq_next;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_data_reg <= '0;
            status_reg  <= '0;
            command_reg <= '0;
            control_reg <= '0;
            irq_reg     <= 1'b0;
        end
        else if (en)
        begin
            rx_data_reg <= rx_data_next;
            status_reg  <= status_next;
            command_reg <= command_next;
            control_reg <= control_next;
            irq_reg     <= irq_next;
        end
    end

endmodule

/* design/acia_checker.sv */
module acia_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input acia_pkg::out_item_t out_data
);
    import acia_pkg::*;

    // A stalled response beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("response changed while stalled");

    // A response appears only for an earlier accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("response without matching request");

    // A beat never both reads a register and sends a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.tx_valid |-> out_data.read_data == 8'h00)
        else $error("read data alongside transmit");

    // No outgoing byte without transmit valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.tx_valid |-> out_data.tx_data == 8'h00)
        else $error("tx data without tx valid");

endmodule

bind acia_serial_register_model acia_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (response.valid),
    .out_ready (response.ready),
    .out_data  (response.data)
);

/* tb/acia_serial_register_model_tb.sv */
`timescale 1ns / 100ps

module acia_serial_register_model_tb;
    import acia_pkg::*;

    // Command code that the block must leave without effect
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_BEATS  = 550;
    localparam int HOLD_CYCLES   = 60;
    localparam int DRAIN_CYCLES  = 8;
    localparam int STALL_LIMIT   = 3000;
    localparam int PRINT_LIMIT   = 100;

    typedef struct {
        in_item_t  beat;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    acia_stream_if #(.T(in_item_t))  req_if ();
    acia_stream_if #(.T(out_item_t)) rsp_if ();

    acia_serial_register_model uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_if),
        .response (rsp_if)
    );

    // Shadow copy of the adapter registers
    logic [7:0] shadow_rxd;
    logic [7:0] shadow_status;
    logic [7:0] shadow_cmd;
    logic [7:0] shadow_ctrl;
    logic       shadow_irq;

    out_item_t  pending_rsp[$];
    int         err_count;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         idle_phase;
    bit         beat_typed;
    out_item_t  beat_want;
    int         quiet_cycles;

    // Clock and reset
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Interrupt recompute after a state change
    task automatic refresh_irq();
        bit active;
        active = ((shadow_status & ST_RXFULL) != 0) ||
                 (((shadow_status & ST_TXEMPTY) != 0) && ((shadow_cmd & CR_TXMASK) == CR_TXIRQ));
        if (active)
            shadow_status = shadow_status | ST_IRQ;
        else
            shadow_status = shadow_status & ~ST_IRQ;
        shadow_irq = active && ((shadow_cmd & CR_ECHO) != 0);
    endtask

    // Expected response of one request beat; advances the shadow registers
    task automatic predict_response(input in_item_t b, output out_item_t r);
        r = '0;
        case (b.command)
            CMD_TICK:
            begin
                if (b.rx_ready)
                begin
                    if ((shadow_status & ST_RXFULL) != 0)
                        shadow_status = shadow_status | ST_OVERRUN;
                    shadow_rxd    = b.rx_byte;
                    shadow_status = shadow_status | ST_RXFULL;
                    if ((shadow_cmd & CR_ECHO) != 0)
                    begin
                        r.tx_valid = 1'b1;
                        r.tx_data  = b.rx_byte;
                    end
                end
                if (b.tx_ready)
                    shadow_status = shadow_status | ST_TXEMPTY;
                if (b.rx_ready || b.tx_ready)
                    refresh_irq();
            end
            CMD_READ:
            begin
                case (b.reg_addr)
                    ADDR_DATA:
                    begin
                        shadow_status = shadow_status & ~ST_LOWBITS;
                        refresh_irq();
                        r.read_data = shadow_rxd;
                    end
                    ADDR_STATUS:  r.read_data = shadow_status;
                    ADDR_COMMAND: r.read_data = shadow_cmd;
                    default:      r.read_data = shadow_ctrl;
                endcase
            end
            CMD_WRITE:
            begin
                case (b.reg_addr)
                    ADDR_DATA:
                    begin
                        r.tx_valid = 1'b1;
                        r.tx_data  = b.write_data;
                    end
                    ADDR_STATUS:
                    begin
                        // soft reset: written byte ignored
                        shadow_cmd    = shadow_cmd | CR_RESET;
                        shadow_status = shadow_status | ST_OVERRUN;
                    end
                    ADDR_COMMAND: shadow_cmd  = b.write_data;
                    default:      shadow_ctrl = b.write_data;
                endcase
                refresh_irq();
            end
            default: ;
        endcase
        r.irq = shadow_irq;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < PRINT_LIMIT)
            $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    // Accepted beats on both channels: check responses, predict requests
    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        out_item_t pred;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got = rsp_if.data;
                if (pending_rsp.size() == 0)
                begin
                    report_mismatch("unexpected response beat", 32'(got), 0);
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", 32'(got.read_data),
                                        32'(want.read_data));
                    if (got.tx_valid !== want.tx_valid)
                        report_mismatch("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
                    if (got.tx_data !== want.tx_data)
                        report_mismatch("tx_data", 32'(got.tx_data), 32'(want.tx_data));
                    if (got.irq !== want.irq)
                        report_mismatch("irq", 32'(got.irq), 32'(want.irq));
                end
            end
            if (req_if.valid && req_if.ready)
            begin
                predict_response(req_if.data, pred);
                if (beat_typed)
                    pending_rsp.push_back(beat_want);
                else
                    pending_rsp.push_back(pred);
            end
        end
    end

    // Watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout after %0d idle cycles", quiet_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Response side: random back-pressure, one long hold-off
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (idle_phase == 2 && !hold_done)
            begin
                hold_done = 1'b1;
                for (int k = 0; k < HOLD_CYCLES; k++)
                begin
                    rsp_if.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_beat(input in_item_t b, input bit typed, input out_item_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= b;
        beat_typed   <= typed;
        beat_want    <= want;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    function automatic dir_row_t row(logic [1:0] c, logic [1:0] a, logic [7:0] wd,
                                     int rxr, int txr, logic [7:0] rxb, int typed,
                                     logic [7:0] rd, int txv, logic [7:0] txd, int irq);
        dir_row_t d;
        d.beat.command    = c;
        d.beat.reg_addr   = a;
        d.beat.write_data = wd;
        d.beat.rx_ready   = 1'(rxr);
        d.beat.tx_ready   = 1'(txr);
        d.beat.rx_byte    = rxb;
        d.typed           = 1'(typed);
        d.want.read_data  = rd;
        d.want.tx_valid   = 1'(txv);
        d.want.tx_data    = txd;
        d.want.irq        = 1'(irq);
        return d;
    endfunction

    // Random beat, weighted toward modes that reach echo and tx interrupts
    function automatic in_item_t random_beat();
        in_item_t   b;
        int         pick;
        int         sel;
        logic [7:0] modes[4];
        modes = '{8'h00, 8'h04, 8'h10, 8'h14};
        b.reg_addr   = 2'($urandom);
        b.write_data = 8'($urandom);
        b.rx_ready   = 1'($urandom);
        b.tx_ready   = 1'($urandom);
        b.rx_byte    = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 38)
        begin
            b.command = CMD_TICK;
        end
        else if (pick < 68)
        begin
            b.command = CMD_READ;
        end
        else if (pick < 96)
        begin
            b.command = CMD_WRITE;
            sel = $urandom_range(15);
            if (sel < 5)
                b.reg_addr = ADDR_DATA;
            else if (sel < 6)
                b.reg_addr = ADDR_STATUS;
            else if (sel < 12)
            begin
                b.reg_addr = ADDR_COMMAND;
                if ($urandom_range(1) == 0)
                    b.write_data = (b.write_data & 8'hE3) | modes[2'($urandom_range(3))];
            end
            else
                b.reg_addr = ADDR_CONTROL;
        end
        else
        begin
            b.command = CMD_UNUSED;
        end
        return b;
    endfunction

    // Request side: directed table, then random beats in three idle phases
    initial
    begin
        dir_row_t  dir_rows[$];
        out_item_t none;
        none          = '0;
        err_count     = 0;
        quiet_cycles  = 0;
        idle_phase    = 0;
        send_idle_pct = 22;
        recv_idle_pct = 80;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        beat_typed   <= 1'b0;
        beat_want    <= '0;

        dir_rows = '{
            // registers after reset
            row(CMD_READ,  ADDR_DATA,    8'h00, 0, 0, 8'h00, 1, 8'h00, 0, 8'h00, 0),
            row(CMD_READ,  ADDR_STATUS,  8'hFF, 1, 1, 8'hFF, 1, 8'h00, 0, 8'h00, 0),
            row(CMD_READ,  ADDR_COMMAND, 8'h00, 0, 0, 8'h00, 1, 8'h00, 0, 8'h00, 0),
            row(CMD_READ,  ADDR_CONTROL, 8'h00, 0, 0, 8'h00, 1, 8'h00, 0, 8'h00, 0),
            // idle tick, control register write and read-back
            row(CMD_TICK,  ADDR_CONTROL, 8'hFF, 0, 0, 8'hFF, 1, 8'h00, 0, 8'h00, 0),
            row(CMD_WRITE, ADDR_CONTROL, 8'hFF, 0, 0, 8'h00, 1, 8'h00, 0, 8'h00, 0),
            row(CMD_READ,  ADDR_CONTROL, 8'h00, 0, 0, 8'h00, 1, 8'hFF, 0, 8'h00, 0),
            row(CMD_WRITE, ADDR_CONTROL, 8'h00, 0, 0, 8'h00, 1, 8'h00, 0, 8'h00, 0),
            // echo on, receive twice for overrun
            row(CMD_WRITE, ADDR_COMMAND, 8'h10, 0, 0, 8'h00, 1, 8'h00, 0, 8'h00, 0),
            row(CMD_TICK,  ADDR_DATA,    8'h00, 1, 0, 8'hFF, 1, 8'h00, 1, 8'hFF, 1),
            row(CMD_TICK,  ADDR_DATA,    8'h00, 1, 0, 8'h00, 1, 8'h00, 1, 8'h00, 1),
            row(CMD_READ,  ADDR_STATUS,  8'h00, 0, 0, 8'h00, 0, 8'h00, 0, 8'h00, 0),
            row(CMD_READ,  ADDR_DATA,    8'h00, 0, 0, 8'h00, 0, 8'h00, 0, 8'h00, 0),
            // transmit-empty interrupt
            row(CMD_WRITE, ADDR_COMMAND, 8'h04, 0, 0, 8'h00, 0, 8'h00, 0, 8'h00, 0),
            row(CMD_TICK,  ADDR_DATA,    8'h00, 0, 1, 8'h00, 0, 8'h00, 0, 8'h00, 0),
            row(CMD_WRITE, ADDR_COMMAND, 8'h14, 0, 0, 8'h00, 0, 8'h00, 0, 8'h00, 0),
            // both flags on one tick
            row(CMD_TICK,  ADDR_DATA,    8'h00, 1, 1, 8'hA5, 0, 8'h00, 0, 8'h00, 0),
            row(CMD_READ,  ADDR_STATUS,  8'h00, 0, 0, 8'h00, 0, 8'h00, 0, 8'h00, 0),
            // data writes at the extremes
            row(CMD_WRITE, ADDR_DATA,    8'hFF, 0, 0, 8'h00, 1, 8'h00, 1, 8'hFF, 1),
            row(CMD_WRITE, ADDR_DATA,    8'h00, 0, 0, 8'h00, 1, 8'h00, 1, 8'h00, 1),
            // soft reset through the status address
            row(CMD_WRITE, ADDR_STATUS,  8'h5A, 0, 0, 8'h00, 0, 8'h00, 0, 8'h00, 0),
            row(CMD_READ,  ADDR_COMMAND, 8'h00, 0, 0, 8'h00, 0, 8'h00, 0, 8'h00, 0),
            // unused command code
            row(CMD_UNUSED, ADDR_CONTROL, 8'hC3, 1, 1, 8'h3C, 0, 8'h00, 0, 8'h00, 0),
            row(CMD_READ,  ADDR_DATA,    8'h00, 0, 0, 8'h00, 0, 8'h00, 0, 8'h00, 0),
            row(CMD_READ,  ADDR_STATUS,  8'h00, 0, 0, 8'h00, 0, 8'h00, 0, 8'h00, 0)
        };

        shadow_rxd    = '0;
        shadow_status = '0;
        shadow_cmd    = '0;
        shadow_ctrl   = '0;
        shadow_irq    = 1'b0;

        wait (rst_n === 1'b1);
        @(posedge clk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == RANDOM_BEATS / 3)
            begin
                idle_phase    = 1;
                send_idle_pct = 80;
                recv_idle_pct = 22;
            end
            else if (n == 2 * RANDOM_BEATS / 3)
            begin
                idle_phase    = 2;
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_beat(random_beat(), 1'b0, none);
        end
        req_if.valid <= 1'b0;

        // drain
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
